@@ rtl/sse_pkg.sv @@
// ----------------------------------------------------------------------------
// Stable sort engine package
// Shared defaults and the sequencer state type of the stable sort engine.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int TAG_WIDTH_DEF = 16;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PRIME,
        ST_MERGE,
        ST_EMIT
    } t_state;

endpackage

@@ rtl/stable_sort_engine_top.sv @@
// ----------------------------------------------------------------------------
// Stable sort engine
// Loads keyed entries, sorts them by unsigned key with a stable bottom-up
// merge over two entry banks, and streams the sorted sequence out.
// ----------------------------------------------------------------------------
// Entries are loaded one per cycle while busy is low; the beat with i_last
// high ends the sequence and raises busy. For n stored entries the engine
// then runs ceil(log2 n) merge passes, each a prime state and then merge
// states in which a single compare-and-select unit writes one entry per
// cycle into the other bank, followed by a prime state for the bank read
// and the emit states. Results come out one per cycle on o_valid, each
// registered in the cycle after its emit state, and the receiver cannot
// stall them; busy falls in the cycle that carries the final result.
// Entries beyond DEPTH are dropped and o_overflow is set on every result
// of that sequence.
module stable_sort_engine_top #(
    parameter int DEPTH     = sse_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = sse_pkg::KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = sse_pkg::TAG_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [TAG_WIDTH-1:0] i_tag,
    input  logic                 i_last,
    output logic                 o_valid,
    output logic [KEY_WIDTH-1:0] o_sorted_key,
    output logic [TAG_WIDTH-1:0] o_sorted_tag,
    output logic                 o_final_res,
    output logic                 o_overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = CW + 2;
    localparam int EW = KEY_WIDTH + TAG_WIDTH;

    sse_pkg::t_state r_state, n_state;

    logic [CW-1:0]        r_count, n_count;
    logic                 r_drop, n_drop;
    logic [CW-1:0]        r_n, n_n;
    logic [PW-1:0]        r_w, n_w;
    logic [CW-1:0]        r_lo, n_lo;
    logic [CW-1:0]        r_a, n_a;
    logic [CW-1:0]        r_b, n_b;
    logic [CW-1:0]        r_o, n_o;
    logic                 r_sel, n_sel;
    logic                 r_valid, n_valid;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [TAG_WIDTH-1:0] r_tag, n_tag;
    logic                 r_final, n_final;
    logic                 r_ovf, n_ovf;

    logic [EW-1:0] w_rd0_a, w_rd0_b, w_rd1_a, w_rd1_b;
    logic [EW-1:0] w_src_a, w_src_b, w_pick;
    logic          w_we0, w_we1;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;

    logic          w_accept;
    logic          w_room;
    logic [CW-1:0] w_count_after;
    logic [PW-1:0] w_n_ext, w_mid_sum, w_hi_sum, w_mid, w_hi;
    logic [PW-1:0] w_lo_next, w_b_sum, w_w2;
    logic          w_a_ok, w_b_ok, w_take_a;
    logic [CW-1:0] w_o_inc;
    logic          w_pass_done, w_pair_done, w_emit_last;

    // Both banks read at the next pointers, so read data always matches r_a and r_b.
    sse_bank #(.DEPTH(DEPTH), .WIDTH(EW)) u_bank0 (
        .i_clk     (i_clk),
        .i_we      (w_we0),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (n_a[AW-1:0]),
        .i_raddr_b (n_b[AW-1:0]),
        .o_rdata_a (w_rd0_a),
        .o_rdata_b (w_rd0_b)
    );

    sse_bank #(.DEPTH(DEPTH), .WIDTH(EW)) u_bank1 (
        .i_clk     (i_clk),
        .i_we      (w_we1),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (n_a[AW-1:0]),
        .i_raddr_b (n_b[AW-1:0]),
        .o_rdata_a (w_rd1_a),
        .o_rdata_b (w_rd1_b)
    );

    assign busy     = (r_state != sse_pkg::ST_LOAD);
    assign w_accept = start && (r_state == sse_pkg::ST_LOAD);

    assign w_room        = (r_count < CW'(DEPTH));
    assign w_count_after = r_count + CW'(w_room);

    assign w_src_a = r_sel ? w_rd1_a : w_rd0_a;
    assign w_src_b = r_sel ? w_rd1_b : w_rd0_b;

    // Run bounds of the current pair, clipped to the sequence length.
    assign w_n_ext   = PW'(r_n);
    assign w_w2      = r_w << 1;
    assign w_mid_sum = PW'(r_lo) + r_w;
    assign w_hi_sum  = PW'(r_lo) + w_w2;
    assign w_mid     = (w_mid_sum > w_n_ext) ? w_n_ext : w_mid_sum;
    assign w_hi      = (w_hi_sum > w_n_ext) ? w_n_ext : w_hi_sum;

    // Equal keys take the left run first, which keeps the sort stable.
    assign w_a_ok   = (PW'(r_a) < w_mid);
    assign w_b_ok   = (PW'(r_b) < w_hi);
    assign w_take_a = w_a_ok && (!w_b_ok ||
                      (w_src_a[EW-1:TAG_WIDTH] <= w_src_b[EW-1:TAG_WIDTH]));
    assign w_pick   = w_take_a ? w_src_a : w_src_b;

    assign w_o_inc     = r_o + CW'(1);
    assign w_pass_done = (w_o_inc == r_n);
    assign w_pair_done = (PW'(w_o_inc) == w_hi);
    assign w_lo_next   = w_hi_sum;
    assign w_b_sum     = w_hi_sum + r_w;
    assign w_emit_last = ((r_a + CW'(1)) == r_n);

    assign w_we0   = (w_accept && w_room) || ((r_state == sse_pkg::ST_MERGE) && r_sel);
    assign w_we1   = (r_state == sse_pkg::ST_MERGE) && !r_sel;
    assign w_waddr = (r_state == sse_pkg::ST_LOAD) ? r_count[AW-1:0] : r_o[AW-1:0];
    assign w_wdata = (r_state == sse_pkg::ST_LOAD) ? {i_key, i_tag} : w_pick;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sse_pkg::ST_LOAD: begin
                if (w_accept && i_last) begin
                    n_state = sse_pkg::ST_PRIME;
                end
            end
            sse_pkg::ST_PRIME: begin
                if (r_w < w_n_ext) begin
                    n_state = sse_pkg::ST_MERGE;
                end else begin
                    n_state = sse_pkg::ST_EMIT;
                end
            end
            sse_pkg::ST_MERGE: begin
                if (w_pass_done) begin
                    n_state = sse_pkg::ST_PRIME;
                end
            end
            sse_pkg::ST_EMIT: begin
                if (w_emit_last) begin
                    n_state = sse_pkg::ST_LOAD;
                end
            end
            default: n_state = sse_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_drop  = r_drop;
        n_n     = r_n;
        n_w     = r_w;
        n_lo    = r_lo;
        n_a     = r_a;
        n_b     = r_b;
        n_o     = r_o;
        n_sel   = r_sel;
        n_valid = 1'b0;
        n_key   = w_src_a[EW-1:TAG_WIDTH];
        n_tag   = w_src_a[TAG_WIDTH-1:0];
        n_final = w_emit_last;
        n_ovf   = r_drop;
        case (r_state)
            sse_pkg::ST_LOAD: begin
                if (w_accept) begin
                    n_count = w_count_after;
                    n_drop  = r_drop || !w_room;
                    if (i_last) begin
                        n_count = '0;
                        n_n     = w_count_after;
                        n_w     = PW'(1);
                        n_lo    = '0;
                        n_a     = '0;
                        n_b     = CW'(1);
                        n_o     = '0;
                        n_sel   = 1'b0;
                    end
                end
            end
            sse_pkg::ST_PRIME: begin
                n_a = r_a;
            end
            sse_pkg::ST_MERGE: begin
                n_o = w_o_inc;
                if (w_take_a) begin
                    n_a = r_a + CW'(1);
                end else begin
                    n_b = r_b + CW'(1);
                end
                if (w_pass_done) begin
                    // The written bank becomes the source of the next pass.
                    n_sel = !r_sel;
                    n_w   = w_w2;
                    n_lo  = '0;
                    n_a   = '0;
                    n_b   = (w_w2 > w_n_ext) ? r_n : w_w2[CW-1:0];
                    n_o   = '0;
                end else if (w_pair_done) begin
                    n_lo = w_lo_next[CW-1:0];
                    n_a  = w_lo_next[CW-1:0];
                    n_b  = (w_b_sum > w_n_ext) ? r_n : w_b_sum[CW-1:0];
                end
            end
            sse_pkg::ST_EMIT: begin
                n_valid = 1'b1;
                n_a     = r_a + CW'(1);
                if (w_emit_last) begin
                    n_drop = 1'b0;
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sse_pkg::ST_LOAD;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_w     <= n_w;
        r_lo    <= n_lo;
        r_a     <= n_a;
        r_b     <= n_b;
        r_o     <= n_o;
        r_key   <= n_key;
        r_tag   <= n_tag;
        r_final <= n_final;
        r_ovf   <= n_ovf;
    end

    assign o_valid      = r_valid;
    assign o_sorted_key = r_key;
    assign o_sorted_tag = r_tag;
    assign o_final_res  = r_final;
    assign o_overflow   = r_ovf;

`ifndef ASSERT_OFF
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ($past(r_state) == sse_pkg::ST_EMIT))
        else $error("result beat without an emit cycle");

    a_merge_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sse_pkg::ST_MERGE) |-> (r_o < r_n))
        else $error("merge output pointer past sequence length");

    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_final_res) |-> !busy)
        else $error("engine still busy on final result beat");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_count <= CW'(DEPTH)))
        else $error("entry count above store depth");
`endif

endmodule

@@ rtl/sse_bank.sv @@
// ----------------------------------------------------------------------------
// Stable sort engine entry bank
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module sse_bank #(
    parameter int DEPTH = sse_pkg::DEPTH_DEF,
    parameter int WIDTH = sse_pkg::KEY_WIDTH_DEF + sse_pkg::TAG_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

@@ sim/stable_sort_engine_top_tb.sv @@
// ----------------------------------------------------------------------------
// Stable sort engine testbench
// Loads keyed sequences into the engine and checks each sorted beat against a
// stable insertion-sort predictor or a typed one-entry expectation. The directed
// table comes first, then random sequences of mixed lengths, with ties, full
// stores and dropped entries.
module stable_sort_engine_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = sse_pkg::DEPTH_DEF;
    localparam int KW           = sse_pkg::KEY_WIDTH_DEF;
    localparam int TW           = sse_pkg::TAG_WIDTH_DEF;
    localparam int ITEM_TARGET  = 130;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        logic [KW-1:0] key;
        logic [TW-1:0] tag;
        logic          final_res;
        logic          overflow;
    } sorted_beat_t;

    typedef struct {
        logic [KW-1:0] key;
        logic [TW-1:0] tag;
        logic          last;
        bit            typed;
        sorted_beat_t  want;
    } stim_row_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic [KW-1:0] i_key;
    logic [TW-1:0] i_tag;
    logic          i_last;
    logic          o_valid;
    logic [KW-1:0] o_sorted_key;
    logic [TW-1:0] o_sorted_tag;
    logic          o_final_res;
    logic          o_overflow;

    // Typed expectation travels with the beat it belongs to.
    bit           typed_valid;
    sorted_beat_t typed_want;

    // Predictor state: entries of the sequence being loaded.
    logic [KW-1:0] held_key [DEPTH];
    logic [TW-1:0] held_tag [DEPTH];
    int            held_count;
    bit            held_dropped;

    sorted_beat_t fresh_beats[$];
    sorted_beat_t pending_sorted[$];
    stim_row_t    plan[$];

    int accepted;
    int quiet_cycles;
    int err_count;
    int idle_pct;

    stable_sort_engine_top #(
        .DEPTH    (DEPTH),
        .KEY_WIDTH(KW),
        .TAG_WIDTH(TW)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_key       (i_key),
        .i_tag       (i_tag),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .o_sorted_key(o_sorted_key),
        .o_sorted_tag(o_sorted_tag),
        .o_final_res (o_final_res),
        .o_overflow  (o_overflow)
    );

    always #2 i_clk = ~i_clk;

    task automatic flag_mismatch(input string msg);
        if (err_count < PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        err_count++;
    endtask

    // Stores one entry; on the last beat, sorts with a stable insertion sort
    // and leaves the sorted beats in fresh_beats.
    task automatic absorb_entry(input logic [KW-1:0] key, input logic [TW-1:0] tag,
                                input logic last);
        logic [KW-1:0] k_arr [DEPTH];
        logic [TW-1:0] t_arr [DEPTH];
        logic [KW-1:0] k_cur;
        logic [TW-1:0] t_cur;
        sorted_beat_t  beat;
        int            i;
        int            j;
        fresh_beats.delete();
        if (held_count < DEPTH) begin
            held_key[held_count] = key;
            held_tag[held_count] = tag;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (last) begin
            for (i = 0; i < held_count; i++) begin
                k_arr[i] = held_key[i];
                t_arr[i] = held_tag[i];
            end
            for (i = 1; i < held_count; i++) begin
                k_cur = k_arr[i];
                t_cur = t_arr[i];
                j = i - 1;
                // Strictly greater keeps equal keys in arrival order.
                while (j >= 0 && k_arr[j] > k_cur) begin
                    k_arr[j+1] = k_arr[j];
                    t_arr[j+1] = t_arr[j];
                    j--;
                end
                k_arr[j+1] = k_cur;
                t_arr[j+1] = t_cur;
            end
            for (i = 0; i < held_count; i++) begin
                beat.key       = k_arr[i];
                beat.tag       = t_arr[i];
                beat.final_res = (i == held_count - 1);
                beat.overflow  = held_dropped;
                fresh_beats.push_back(beat);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        sorted_beat_t want;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (start && !busy) begin
                moved = 1'b1;
                accepted++;
                absorb_entry(i_key, i_tag, i_last);
                if (typed_valid) begin
                    pending_sorted.push_back(typed_want);
                end else begin
                    foreach (fresh_beats[n]) pending_sorted.push_back(fresh_beats[n]);
                end
            end
            if (o_valid) begin
                moved = 1'b1;
                if (pending_sorted.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result key %h tag %h",
                                            o_sorted_key, o_sorted_tag));
                end else begin
                    want = pending_sorted.pop_front();
                    if (o_sorted_key !== want.key)
                        flag_mismatch($sformatf("sorted_key %h, expected %h",
                                                o_sorted_key, want.key));
                    if (o_sorted_tag !== want.tag)
                        flag_mismatch($sformatf("sorted_tag %h, expected %h",
                                                o_sorted_tag, want.tag));
                    if (o_final_res !== want.final_res)
                        flag_mismatch($sformatf("final_res %b, expected %b",
                                                o_final_res, want.final_res));
                    if (o_overflow !== want.overflow)
                        flag_mismatch($sformatf("overflow %b, expected %b",
                                                o_overflow, want.overflow));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("stable_sort_engine_top_tb failed");
                $finish;
            end
        end
    end

    task automatic send_entry(input logic [KW-1:0] key, input logic [TW-1:0] tag,
                              input logic last, input bit typed, input sorted_beat_t want);
        int seen;
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_key       <= key;
        i_tag       <= tag;
        i_last      <= last;
        typed_valid <= typed;
        typed_want  <= want;
        start       <= 1'b1;
        seen = accepted;
        do @(negedge i_clk); while (accepted == seen);
    endtask

    // Holds the sender off until every expected beat has come back.
    task automatic wait_drained();
        if (pending_sorted.size() != 0) begin
            start <= 1'b0;
            while (pending_sorted.size() != 0) @(negedge i_clk);
        end
    endtask

    task automatic add_row(input logic [KW-1:0] key, input logic [TW-1:0] tag,
                           input logic last);
        stim_row_t row;
        row.key   = key;
        row.tag   = tag;
        row.last  = last;
        row.typed = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endtask

    // A one-entry sequence comes straight back, marked final.
    task automatic add_single(input logic [KW-1:0] key, input logic [TW-1:0] tag);
        stim_row_t row;
        row.key   = key;
        row.tag   = tag;
        row.last  = 1'b1;
        row.typed = 1'b1;
        row.want  = '{key: key, tag: tag, final_res: 1'b1, overflow: 1'b0};
        plan.push_back(row);
    endtask

    initial begin : stimulus
        logic [KW-1:0] tie_keys [4];
        logic [KW-1:0] key;
        int            items;
        int            seq_idx;
        int            kind;
        int            len;
        int            j;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_key        = '0;
        i_tag        = '0;
        i_last       = 1'b0;
        typed_valid  = 1'b0;
        typed_want   = '0;
        held_count   = 0;
        held_dropped = 1'b0;
        accepted     = 0;
        quiet_cycles = 0;
        err_count    = 0;
        idle_pct     = 11;
        items        = 0;

        add_single('0, '0);
        add_single('1, '1);
        add_single(32'h1234_5678, 16'hA5A5);
        // Extremes mixed, with a tie at each end.
        add_row(32'hFFFF_FFFF, 16'd1, 1'b0);
        add_row(32'h0000_0000, 16'd2, 1'b0);
        add_row(32'h8000_0000, 16'd3, 1'b0);
        add_row(32'h0000_0000, 16'd4, 1'b0);
        add_row(32'hFFFF_FFFF, 16'd5, 1'b1);
        add_row(32'd1, 16'd10, 1'b0);
        add_row(32'd2, 16'd11, 1'b1);
        add_row(32'd2, 16'd12, 1'b0);
        add_row(32'd1, 16'd13, 1'b1);
        for (j = 0; j < 4; j++) add_row(32'd7, 16'(20 + j), j == 3);
        // Odd length so the last bottom-up run is short.
        for (j = 0; j < 5; j++) add_row(32'(50 - 10 * j), 16'(30 + j), j == 4);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[r]) begin
            send_entry(plan[r].key, plan[r].tag, plan[r].last, plan[r].typed,
                       plan[r].want);
            items++;
        end
        wait_drained();

        seq_idx = 0;
        while (items < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (seq_idx == 0) begin
                // Store full, with the last beat itself dropped.
                kind = 95;
                len  = DEPTH + 1;
            end else if (kind < 50) begin
                len = $urandom_range(1, 10);
            end else if (kind < 70) begin
                len = $urandom_range(2, 16);
            end else if (kind < 85) begin
                len = $urandom_range(17, DEPTH);
            end else begin
                len = $urandom_range(DEPTH + 1, DEPTH + 6);
            end
            // The final sequence is cut short so the run stays near its item count.
            if (len > ITEM_TARGET - items) len = ITEM_TARGET - items;
            foreach (tie_keys[t]) tie_keys[t] = $urandom;
            idle_pct = (seq_idx >= 3 && seq_idx < 8) ? 0 : 11;
            if ($urandom_range(0, 9) == 0) wait_drained();
            for (j = 0; j < len; j++) begin
                if (kind >= 50 && kind < 70)
                    key = tie_keys[$urandom_range(0, 3)];
                else
                    key = $urandom;
                send_entry(key, TW'($urandom), j == len - 1, 1'b0, '0);
                items++;
            end
            seq_idx++;
        end

        start <= 1'b0;
        @(negedge i_clk);
        while (pending_sorted.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (err_count == 0) begin
            $display("stable_sort_engine_top_tb passed");
        end else begin
            $display("stable_sort_engine_top_tb failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/sse_pkg.sv
rtl/sse_bank.sv
rtl/stable_sort_engine_top.sv
sim/stable_sort_engine_top_tb.sv
